FILE: rtl/complex_henon_map_stepper_top_defines.svh
// ----------------------------------------------------------------------------
// complex henon map stepper assertion macros
// Concurrent checks clocked on clock; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_HENON_MAP_STEPPER_TOP_DEFINES_SVH
`define COMPLEX_HENON_MAP_STEPPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check that is ignored while reset is high
`define CHMS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also holds while reset is high
`define CHMS_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CHMS_ASSERT(lbl, prop, msg)
`define CHMS_ASSERT_NR(lbl, prop, msg)
`endif

`endif

FILE: rtl/chms_pkg.sv
// ----------------------------------------------------------------------------
// chms_pkg
// Widths, codes and shared helpers of the complex henon map stepper.
// ----------------------------------------------------------------------------
package chms_pkg;

   // number formats
   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 28;
   localparam int ACC_W     = WORD_W + 8;
   localparam int PROD_W    = WORD_W + ACC_W;
   localparam int D_W       = 2 * WORD_W;
   localparam int QUOT_BITS = WORD_W + 1;
   localparam int Q_W       = QUOT_BITS + 1;
   localparam int MAG_SHIFT = QUOT_BITS - FRAC_BITS;
   localparam int CNT_W     = $clog2(QUOT_BITS + 1);
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic signed [WORD_W-1:0] A_REAL_RST = -32'sd80530637;
   localparam logic signed [WORD_W-1:0] A_IMAG_RST = '0;
   localparam logic signed [WORD_W-1:0] C_REAL_RST = -32'sd359703511;
   localparam logic signed [WORD_W-1:0] C_IMAG_RST = '0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_REAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_IMAG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG = 2'd3;

   // item operations
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_FWD  = 2'd1;
   localparam logic [1:0] OP_INV  = 2'd2;

   // multiplier operand a
   localparam logic [2:0] A_XR = 3'd0;
   localparam logic [2:0] A_XI = 3'd1;
   localparam logic [2:0] A_YR = 3'd2;
   localparam logic [2:0] A_YI = 3'd3;
   localparam logic [2:0] A_AR = 3'd4;
   localparam logic [2:0] A_AI = 3'd5;

   // multiplier operand b
   localparam logic [2:0] B_XR = 3'd0;
   localparam logic [2:0] B_XI = 3'd1;
   localparam logic [2:0] B_YR = 3'd2;
   localparam logic [2:0] B_YI = 3'd3;
   localparam logic [2:0] B_AR = 3'd4;
   localparam logic [2:0] B_AI = 3'd5;
   localparam logic [2:0] B_H0 = 3'd6;
   localparam logic [2:0] B_H1 = 3'd7;

   // accumulator operations
   localparam logic [3:0] ACC_NONE         = 4'd0;
   localparam logic [3:0] ACC_LD_CRE       = 4'd1;
   localparam logic [3:0] ACC_LD_CRE_MXR   = 4'd2;
   localparam logic [3:0] ACC_SAVE_CIM     = 4'd3;
   localparam logic [3:0] ACC_SAVE_CIM_MXI = 4'd4;
   localparam logic [3:0] ACC_SAVE1        = 4'd5;
   localparam logic [3:0] ACC_ADD_R        = 4'd6;
   localparam logic [3:0] ACC_SUB_R        = 4'd7;
   localparam logic [3:0] ACC_ADD_R2       = 4'd8;

   // divisor accumulator operations
   localparam logic [1:0] D_NONE = 2'd0;
   localparam logic [1:0] D_CLR  = 2'd1;
   localparam logic [1:0] D_ADD  = 2'd2;

   // numerator accumulator operations
   localparam logic [1:0] N_NONE = 2'd0;
   localparam logic [1:0] N_LOAD = 2'd1;
   localparam logic [1:0] N_ADD  = 2'd2;
   localparam logic [1:0] N_SUB  = 2'd3;

   // quotient capture targets
   localparam logic [1:0] CAP_NONE = 2'd0;
   localparam logic [1:0] CAP_0    = 2'd1;
   localparam logic [1:0] CAP_1    = 2'd2;

   // point update kinds
   localparam logic [2:0] CM_NONE  = 3'd0;
   localparam logic [2:0] CM_LOAD  = 3'd1;
   localparam logic [2:0] CM_KEEP  = 3'd2;
   localparam logic [2:0] CM_FAULT = 3'd3;
   localparam logic [2:0] CM_FWD   = 3'd4;
   localparam logic [2:0] CM_INV   = 3'd5;

   typedef struct packed {
      logic       mul_en;
      logic [2:0] a_sel;
      logic [2:0] b_sel;
      logic [3:0] acc_op;
      logic [1:0] d_op;
      logic [1:0] n_op;
      logic       div_start;
      logic [1:0] div_cap;
      logic [2:0] commit;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic a_zero;
      logic div_done;
   } status_type;

   typedef struct packed {
      logic                     clip;
      logic signed [WORD_W-1:0] value;
   } sat_type;

   localparam logic signed [ACC_W-1:0] ACC_MAX =
      {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN =
      {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

   // sign extend a word to accumulator width
   function automatic logic signed [ACC_W-1:0] wext(input logic signed [WORD_W-1:0] v);
      return {{(ACC_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   // clip an accumulator value to the word range
   function automatic sat_type sat_word(input logic signed [ACC_W-1:0] v);
      sat_type s;
      s.clip  = 1'b0;
      s.value = v[WORD_W-1:0];
      if (v > ACC_MAX) begin
         s.clip  = 1'b1;
         s.value = ACC_MAX[WORD_W-1:0];
      end else if (v < ACC_MIN) begin
         s.clip  = 1'b1;
         s.value = ACC_MIN[WORD_W-1:0];
      end
      return s;
   endfunction

endpackage

FILE: rtl/complex_henon_map_stepper_top.sv
// ----------------------------------------------------------------------------
// complex_henon_map_stepper_top
// Complex henon map on a stored point, Q4.28, with load, forward and inverse.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (op plus load point), taken on req_valid & req_ready.
//   rsp_* returns the new point and flags, taken on rsp_valid & rsp_ready.
//   csr_wr_en writes a_real, a_imag, c_real, c_imag by csr_index, while idle.
// Operation (one item at a time, through one shared 32x40 multiplier):
//   load, unused op or inverse with a = 0: point or flags updated as the
//   item is taken, then published with no micro steps
//   forward step: ten micro steps through the multiplier and accumulator
//   inverse step: micro steps dominated by two 33-step restoring
//   divisions by |a|^2, the sequencer waiting out each one
// The result moves into an output register and req_ready returns in the
// next cycle; with a stalled receiver the next item is computed and then
// waits for the output register to free up, which stalls the sender.
// Reset: point cleared to zero, parameters back to their defaults, no
// result pending.
// ----------------------------------------------------------------------------
module complex_henon_map_stepper_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic signed [chms_pkg::WORD_W-1:0]  req_load_x_real,
   input  logic signed [chms_pkg::WORD_W-1:0]  req_load_x_imag,
   input  logic signed [chms_pkg::WORD_W-1:0]  req_load_y_real,
   input  logic signed [chms_pkg::WORD_W-1:0]  req_load_y_imag,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [chms_pkg::WORD_W-1:0]  rsp_x_real,
   output logic signed [chms_pkg::WORD_W-1:0]  rsp_x_imag,
   output logic signed [chms_pkg::WORD_W-1:0]  rsp_y_real,
   output logic signed [chms_pkg::WORD_W-1:0]  rsp_y_imag,
   output logic                                rsp_saturated,
   output logic                                rsp_divide_fault,
   input  logic                                csr_wr_en,
   input  logic [chms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic signed [chms_pkg::WORD_W-1:0]  csr_wdata
);
   import chms_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   chms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and storage
   chms_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .load_x_real  (req_load_x_real),
      .load_x_imag  (req_load_x_imag),
      .load_y_real  (req_load_y_real),
      .load_y_imag  (req_load_y_imag),
      .x_real       (rsp_x_real),
      .x_imag       (rsp_x_imag),
      .y_real       (rsp_y_real),
      .y_imag       (rsp_y_imag),
      .saturated    (rsp_saturated),
      .divide_fault (rsp_divide_fault)
   );

endmodule

FILE: rtl/chms_div.sv
// ----------------------------------------------------------------------------
// chms_div
// Restoring divider: |n| * 2^FRAC_BITS / d, rounded half away, clipped to a word.
// ----------------------------------------------------------------------------
module chms_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [chms_pkg::PROD_W-1:0]   mag,
   input  logic                          neg,
   input  logic [chms_pkg::D_W-1:0]      divisor,
   output logic                          done,
   output logic signed [chms_pkg::WORD_W-1:0] res,
   output logic                          clip
);
   import chms_pkg::*;

   localparam logic [1:0] DV_IDLE = 2'd0;
   localparam logic [1:0] DV_RUN  = 2'd1;
   localparam logic [1:0] DV_RND  = 2'd2;
   localparam logic [1:0] DV_DONE = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [D_W-1:0]           rem_ff, rem_in;
   logic [QUOT_BITS-1:0]     bits_ff, bits_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic                     neg_ff, neg_in;
   logic                     big_ff, big_in;
   logic signed [WORD_W-1:0] res_ff, res_in;
   logic                     clip_ff, clip_in;

   logic [D_W:0]   trial;
   logic [Q_W-1:0] q_rnd;
   logic           pos_ovf;
   logic           neg_ovf;

   // one quotient bit per cycle, then rounding and clipping
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      bits_in  = bits_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      big_in   = big_ff;
      res_in   = res_ff;
      clip_in  = clip_ff;
      trial    = {rem_ff, bits_ff[QUOT_BITS-1]};
      q_rnd    = q_ff + Q_W'({rem_ff, 1'b0} >= {1'b0, divisor});
      pos_ovf  = (q_rnd[Q_W-1:WORD_W-1] != '0);
      neg_ovf  = (q_rnd[Q_W-1:WORD_W] != '0) ||
                 (q_rnd[WORD_W-1] && (q_rnd[WORD_W-2:0] != '0));
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               // quotient of 2^QUOT_BITS or more always clips
               big_in   = ((mag >> MAG_SHIFT) >= PROD_W'(divisor));
               rem_in   = mag[MAG_SHIFT +: D_W];
               bits_in  = {mag[MAG_SHIFT-1:0], {FRAC_BITS{1'b0}}};
               q_in     = '0;
               neg_in   = neg;
               cnt_in   = CNT_W'(QUOT_BITS);
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = D_W'(trial - {1'b0, divisor});
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = trial[D_W-1:0];
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            bits_in = {bits_ff[QUOT_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = DV_RND;
            end
         end
         DV_RND: begin
            if (neg_ff) begin
               clip_in = big_ff || neg_ovf;
               res_in  = clip_in ? ACC_MIN[WORD_W-1:0] : -q_rnd[WORD_W-1:0];
            end else begin
               clip_in = big_ff || pos_ovf;
               res_in  = clip_in ? ACC_MAX[WORD_W-1:0] : q_rnd[WORD_W-1:0];
            end
            state_in = DV_DONE;
         end
         DV_DONE: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      big_ff  <= big_in;
      res_ff  <= res_in;
      clip_ff <= clip_in;
   end

   assign done = (state_ff == DV_DONE);
   assign res  = res_ff;
   assign clip = clip_ff;

endmodule

FILE: rtl/chms_datapath.sv
// ----------------------------------------------------------------------------
// chms_datapath
// Point and parameter registers, shared multiplier, accumulators and divider.
// ----------------------------------------------------------------------------
module chms_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  chms_pkg::cmd_type                     cmd,
   output chms_pkg::status_type                  status,
   input  logic                                  csr_wr_en,
   input  logic [chms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic signed [chms_pkg::WORD_W-1:0]    csr_wdata,
   input  logic signed [chms_pkg::WORD_W-1:0]    load_x_real,
   input  logic signed [chms_pkg::WORD_W-1:0]    load_x_imag,
   input  logic signed [chms_pkg::WORD_W-1:0]    load_y_real,
   input  logic signed [chms_pkg::WORD_W-1:0]    load_y_imag,
   output logic signed [chms_pkg::WORD_W-1:0]    x_real,
   output logic signed [chms_pkg::WORD_W-1:0]    x_imag,
   output logic signed [chms_pkg::WORD_W-1:0]    y_real,
   output logic signed [chms_pkg::WORD_W-1:0]    y_imag,
   output logic                                  saturated,
   output logic                                  divide_fault
);
   import chms_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_R  = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] HALF_R2 = PROD_W'(1) << (FRAC_BITS - 2);

   logic signed [WORD_W-1:0] a_re_ff, a_re_in, a_im_ff, a_im_in;
   logic signed [WORD_W-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [WORD_W-1:0] xr_ff, xr_in, xi_ff, xi_in, yr_ff, yr_in, yi_ff, yi_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, h0_ff, h0_in, h1_ff, h1_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, n_ff, n_in;
   logic [D_W-1:0]           d_ff, d_in;
   logic signed [WORD_W-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic                     rc0_ff, rc0_in, rc1_ff, rc1_in;
   logic                     clip_ff, clip_in, fault_ff, fault_in;
   logic signed [WORD_W-1:0] oxr_ff, oxr_in, oxi_ff, oxi_in, oyr_ff, oyr_in;
   logic signed [WORD_W-1:0] oyi_ff, oyi_in;
   logic                     osat_ff, osat_in, ofault_ff, ofault_in;

   logic signed [WORD_W-1:0] mul_a;
   logic signed [ACC_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] rnd_r, rnd_r2;
   logic [PROD_W-1:0]        n_mag;
   sat_type                  sat_h0, sat_acc;
   logic                     div_done;
   logic signed [WORD_W-1:0] div_res;
   logic                     div_clip;

   // parameter registers
   always_comb begin
      a_re_in = a_re_ff;
      a_im_in = a_im_ff;
      c_re_in = c_re_ff;
      c_im_in = c_im_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_A_REAL: a_re_in = csr_wdata;
            CSR_A_IMAG: a_im_in = csr_wdata;
            CSR_C_REAL: c_re_in = csr_wdata;
            CSR_C_IMAG: c_im_in = csr_wdata;
         endcase
      end
   end

   // multiplier operands and product register
   always_comb begin
      unique case (cmd.a_sel)
         A_XR:    mul_a = xr_ff;
         A_XI:    mul_a = xi_ff;
         A_YR:    mul_a = yr_ff;
         A_YI:    mul_a = yi_ff;
         A_AR:    mul_a = a_re_ff;
         A_AI:    mul_a = a_im_ff;
         default: mul_a = a_re_ff;
      endcase
      unique case (cmd.b_sel)
         B_XR: mul_b = wext(xr_ff);
         B_XI: mul_b = wext(xi_ff);
         B_YR: mul_b = wext(yr_ff);
         B_YI: mul_b = wext(yi_ff);
         B_AR: mul_b = wext(a_re_ff);
         B_AI: mul_b = wext(a_im_ff);
         B_H0: mul_b = h0_ff;
         B_H1: mul_b = h1_ff;
      endcase
      prod_in = cmd.mul_en ? mul_a * mul_b : prod_ff;
   end

   // rounded products, half up
   assign rnd_r  = (prod_ff + HALF_R) >>> FRAC_BITS;
   assign rnd_r2 = (prod_ff + HALF_R2) >>> (FRAC_BITS - 1);

   // accumulator and holding registers
   always_comb begin
      acc_in = acc_ff;
      h0_in  = h0_ff;
      h1_in  = h1_ff;
      unique case (cmd.acc_op)
         ACC_LD_CRE:     acc_in = wext(c_re_ff);
         ACC_LD_CRE_MXR: acc_in = wext(c_re_ff) - wext(xr_ff);
         ACC_SAVE_CIM: begin
            h0_in  = acc_ff;
            acc_in = wext(c_im_ff);
         end
         ACC_SAVE_CIM_MXI: begin
            h0_in  = acc_ff;
            acc_in = wext(c_im_ff) - wext(xi_ff);
         end
         ACC_SAVE1:  h1_in  = acc_ff;
         ACC_ADD_R:  acc_in = acc_ff + rnd_r[ACC_W-1:0];
         ACC_SUB_R:  acc_in = acc_ff - rnd_r[ACC_W-1:0];
         ACC_ADD_R2: acc_in = acc_ff + rnd_r2[ACC_W-1:0];
         default:    acc_in = acc_ff;
      endcase
   end

   // divisor |a|^2 and exact numerator
   always_comb begin
      unique case (cmd.d_op)
         D_CLR:   d_in = '0;
         D_ADD:   d_in = d_ff + prod_ff[D_W-1:0];
         default: d_in = d_ff;
      endcase
      unique case (cmd.n_op)
         N_LOAD: n_in = prod_ff;
         N_ADD:  n_in = n_ff + prod_ff;
         N_SUB:  n_in = n_ff - prod_ff;
         N_NONE: n_in = n_ff;
      endcase
      n_mag = n_ff[PROD_W-1] ? -n_ff : n_ff;
   end

   chms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .mag     (n_mag),
      .neg     (n_ff[PROD_W-1]),
      .divisor (d_ff),
      .done    (div_done),
      .res     (div_res),
      .clip    (div_clip)
   );

   // quotient capture
   always_comb begin
      r0_in  = r0_ff;
      rc0_in = rc0_ff;
      r1_in  = r1_ff;
      rc1_in = rc1_ff;
      if (cmd.div_cap == CAP_0) begin
         r0_in  = div_res;
         rc0_in = div_clip;
      end
      if (cmd.div_cap == CAP_1) begin
         r1_in  = div_res;
         rc1_in = div_clip;
      end
   end

   // point update
   always_comb begin
      sat_h0   = sat_word(h0_ff);
      sat_acc  = sat_word(acc_ff);
      xr_in    = xr_ff;
      xi_in    = xi_ff;
      yr_in    = yr_ff;
      yi_in    = yi_ff;
      clip_in  = clip_ff;
      fault_in = fault_ff;
      unique case (cmd.commit)
         CM_LOAD: begin
            xr_in    = load_x_real;
            xi_in    = load_x_imag;
            yr_in    = load_y_real;
            yi_in    = load_y_imag;
            clip_in  = 1'b0;
            fault_in = 1'b0;
         end
         CM_KEEP: begin
            clip_in  = 1'b0;
            fault_in = 1'b0;
         end
         CM_FAULT: begin
            clip_in  = 1'b0;
            fault_in = 1'b1;
         end
         CM_FWD: begin
            xr_in    = sat_h0.value;
            xi_in    = sat_acc.value;
            yr_in    = xr_ff;
            yi_in    = xi_ff;
            clip_in  = sat_h0.clip || sat_acc.clip;
            fault_in = 1'b0;
         end
         CM_INV: begin
            xr_in    = yr_ff;
            xi_in    = yi_ff;
            yr_in    = r0_ff;
            yi_in    = r1_ff;
            clip_in  = rc0_ff || rc1_ff;
            fault_in = 1'b0;
         end
         default: begin
            clip_in  = clip_ff;
         end
      endcase
   end

   // result register
   always_comb begin
      oxr_in    = oxr_ff;
      oxi_in    = oxi_ff;
      oyr_in    = oyr_ff;
      oyi_in    = oyi_ff;
      osat_in   = osat_ff;
      ofault_in = ofault_ff;
      if (cmd.publish) begin
         oxr_in    = xr_ff;
         oxi_in    = xi_ff;
         oyr_in    = yr_ff;
         oyi_in    = yi_ff;
         osat_in   = clip_ff;
         ofault_in = fault_ff;
      end
   end

   // parameters and point
   always_ff @(posedge clock) begin
      if (reset) begin
         a_re_ff <= A_REAL_RST;
         a_im_ff <= A_IMAG_RST;
         c_re_ff <= C_REAL_RST;
         c_im_ff <= C_IMAG_RST;
         xr_ff   <= '0;
         xi_ff   <= '0;
         yr_ff   <= '0;
         yi_ff   <= '0;
      end else begin
         a_re_ff <= a_re_in;
         a_im_ff <= a_im_in;
         c_re_ff <= c_re_in;
         c_im_ff <= c_im_in;
         xr_ff   <= xr_in;
         xi_ff   <= xi_in;
         yr_ff   <= yr_in;
         yi_ff   <= yi_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      h0_ff     <= h0_in;
      h1_ff     <= h1_in;
      d_ff      <= d_in;
      n_ff      <= n_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      rc0_ff    <= rc0_in;
      rc1_ff    <= rc1_in;
      clip_ff   <= clip_in;
      fault_ff  <= fault_in;
      oxr_ff    <= oxr_in;
      oxi_ff    <= oxi_in;
      oyr_ff    <= oyr_in;
      oyi_ff    <= oyi_in;
      osat_ff   <= osat_in;
      ofault_ff <= ofault_in;
   end

   assign status.a_zero   = (a_re_ff == '0) && (a_im_ff == '0);
   assign status.div_done = div_done;

   assign x_real       = oxr_ff;
   assign x_imag       = oxi_ff;
   assign y_real       = oyr_ff;
   assign y_imag       = oyi_ff;
   assign saturated    = osat_ff;
   assign divide_fault = ofault_ff;

endmodule

FILE: rtl/chms_ctrl.sv
// ----------------------------------------------------------------------------
// chms_ctrl
// Sequencer: steps the datapath through a map step and hands results out.
// ----------------------------------------------------------------------------
`include "complex_henon_map_stepper_top_defines.svh"

module chms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output chms_pkg::cmd_type    cmd,
   input  chms_pkg::status_type status
);
   import chms_pkg::*;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd14;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_PUB  = 2'd3;

   typedef struct packed {
      cmd_type    cmd;
      logic       last;
      logic [1:0] cap;
   } uop_type;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        op_ff, op_in;
   logic              rsp_valid_ff, rsp_valid_in;
   uop_type           uop;

   // micro step table; each product is registered and used in a later step
   function automatic uop_type step_uop(input logic [1:0] op, input logic [STEP_W-1:0] step);
      uop_type u;
      u = '0;
      if (op == OP_FWD) begin
         unique case (step)
            4'd0: begin
               u.cmd.acc_op = ACC_LD_CRE;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_XR; u.cmd.b_sel = B_XR;
            end
            4'd1: begin
               u.cmd.acc_op = ACC_ADD_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_XI; u.cmd.b_sel = B_XI;
            end
            4'd2: begin
               u.cmd.acc_op = ACC_SUB_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AR; u.cmd.b_sel = B_YR;
            end
            4'd3: begin
               u.cmd.acc_op = ACC_SUB_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AI; u.cmd.b_sel = B_YI;
            end
            4'd4: begin
               u.cmd.acc_op = ACC_ADD_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_XR; u.cmd.b_sel = B_XI;
            end
            4'd5: u.cmd.acc_op = ACC_SAVE_CIM;
            4'd6: begin
               u.cmd.acc_op = ACC_ADD_R2;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AI; u.cmd.b_sel = B_YR;
            end
            4'd7: begin
               u.cmd.acc_op = ACC_SUB_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AR; u.cmd.b_sel = B_YI;
            end
            4'd8: u.cmd.acc_op = ACC_SUB_R;
            4'd9: begin
               u.cmd.commit = CM_FWD;
               u.last       = 1'b1;
            end
            default: u.last = 1'b1;
         endcase
      end else begin
         unique case (step)
            4'd0: begin
               u.cmd.d_op   = D_CLR;
               u.cmd.acc_op = ACC_LD_CRE_MXR;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AR; u.cmd.b_sel = B_AR;
            end
            4'd1: begin
               u.cmd.d_op   = D_ADD;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AI; u.cmd.b_sel = B_AI;
            end
            4'd2: begin
               u.cmd.d_op   = D_ADD;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_YR; u.cmd.b_sel = B_YR;
            end
            4'd3: begin
               u.cmd.acc_op = ACC_ADD_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_YI; u.cmd.b_sel = B_YI;
            end
            4'd4: begin
               u.cmd.acc_op = ACC_SUB_R;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_YR; u.cmd.b_sel = B_YI;
            end
            4'd5: u.cmd.acc_op = ACC_SAVE_CIM_MXI;
            4'd6: u.cmd.acc_op = ACC_ADD_R2;
            4'd7: begin
               u.cmd.acc_op = ACC_SAVE1;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AR; u.cmd.b_sel = B_H0;
            end
            4'd8: begin
               u.cmd.n_op   = N_LOAD;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AI; u.cmd.b_sel = B_H1;
            end
            4'd9: u.cmd.n_op = N_ADD;
            4'd10: begin
               u.cmd.div_start = 1'b1;
               u.cap           = CAP_0;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AR; u.cmd.b_sel = B_H1;
            end
            4'd11: begin
               u.cmd.n_op   = N_LOAD;
               u.cmd.mul_en = 1'b1; u.cmd.a_sel = A_AI; u.cmd.b_sel = B_H0;
            end
            4'd12: u.cmd.n_op = N_SUB;
            4'd13: begin
               u.cmd.div_start = 1'b1;
               u.cap           = CAP_1;
            end
            4'd14: begin
               u.cmd.commit = CM_INV;
               u.last       = 1'b1;
            end
            default: u.last = 1'b1;
         endcase
      end
      return u;
   endfunction

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      uop          = step_uop(op_ff, step_ff);
      req_ready    = (state_ff == ST_IDLE);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_op;
               step_in = '0;
               priority if (req_op == OP_LOAD) begin
                  cmd.commit = CM_LOAD;
                  state_in   = ST_PUB;
               end else if (req_op == OP_FWD) begin
                  state_in = ST_RUN;
               end else if (req_op == OP_INV && !status.a_zero) begin
                  state_in = ST_RUN;
               end else if (req_op == OP_INV) begin
                  cmd.commit = CM_FAULT;
                  state_in   = ST_PUB;
               end else begin
                  cmd.commit = CM_KEEP;
                  state_in   = ST_PUB;
               end
            end
         end
         ST_RUN: begin
            cmd = uop.cmd;
            if (uop.last) begin
               state_in = ST_PUB;
            end else if (uop.cmd.div_start) begin
               state_in = ST_WAIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.div_cap = uop.cap;
               step_in     = step_ff + 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_PUB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         op_ff        <= OP_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `CHMS_ASSERT(a_pub_free, cmd.publish |-> (!rsp_valid_ff || rsp_ready), "result overwritten")
   `CHMS_ASSERT(a_one_item, (req_valid && req_ready) |=> !req_ready, "second item taken")
   `CHMS_ASSERT_NR(a_wait_quiet, (state_ff == ST_WAIT) |-> (cmd.commit == CM_NONE && !cmd.mul_en), "datapath busy while dividing")
   `CHMS_ASSERT(a_step_range, (state_ff == ST_RUN) |-> (step_ff <= STEP_LAST), "step out of range")

endmodule
